@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the allocator design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is asserted.
`define AST_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, off while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ design/ffha_pkg.sv @@
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int unsigned HEAP_BYTES    = 65536;
	localparam int unsigned HEADER_BYTES  = 32;
	localparam int unsigned GRANULE_BYTES = 16;
	// header length in granules
	localparam logic [12:0] HDR_G = 13'(HEADER_BYTES / GRANULE_BYTES);
	// heap limit in granules
	localparam logic [12:0] MAX_G = 13'(HEAP_BYTES / GRANULE_BYTES);

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] ST_ALLOCATED = 2'd0;
	localparam logic [1:0] ST_NO_FIT    = 2'd1;
	localparam logic [1:0] ST_FREED     = 2'd2;

	typedef struct packed {
		logic        func;
		logic [16:0] alloc_size;
		logic [15:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [15:0] given_offset;
		logic [1:0]  status;
	} rsp_t;

	// header entry: allocated mark and payload length in granules
	typedef struct packed {
		logic        used;
		logic [12:0] len;
	} hdr_t;

	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_RD, S_EV, S_WR2, S_NRD, S_NEV, S_FWR
	} state_t;

endpackage

@@ design/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator walking an address-ordered header store.
// ----------------------------------------------------------------------------
// Usage: raise start with a request word on req while busy is low; the word
// is taken at that edge. Allocate rounds alloc_size up to 16 bytes, takes the
// first free block that fits and splits off any rest larger than a header.
// Free clears the named block and merges it with free neighbours.
// Each result word appears on rsp for one cycle with done high; the receiver
// cannot stall, so it must take the word then.
// Each block visited costs a header read, then an evaluation; a split or a
// merge adds a write, and the result word is registered after that.
// A free stops at the named block and reads one neighbour more. The header
// store has a single read port, so blocks are read one at a time.
// Reset and every write to heap_size (wr_en, wr_data) rebuild the heap as
// one free block, while busy stays high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_heap_allocator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  ffha_pkg::req_t   req,
	output logic             done,
	output ffha_pkg::rsp_t   rsp,
	input  logic             wr_en,
	input  logic [16:0]      wr_data
);

	ffha_pkg::state_t state_q, state_d;

	ffha_pkg::hdr_t mem [4096];
	ffha_pkg::hdr_t rdata_q;
	logic [11:0]    rd_addr;
	logic           we;
	logic [11:0]    wa;
	ffha_pkg::hdr_t wd;

	logic [12:0] limit_q;
	logic        func_q;
	logic [12:0] want_q;
	logic [12:0] tgt_q;
	logic        tgt_ok_q;
	logic [12:0] pos_q;
	logic [12:0] prev_pos_q;
	logic [12:0] prev_len_q;
	logic        prev_free_q;
	logic [12:0] base_q;
	logic [12:0] acc_q;
	logic [12:0] nxt_q;
	logic [12:0] rest_q;
	logic        done_q;
	ffha_pkg::rsp_t rsp_q;

	logic [12:0] blk_end;
	logic        fit, split, hit, miss, at_end;
	logic [12:0] cfg_limit;
	logic [12:0] want_in;

	// decode the word just read
	assign blk_end = pos_q + ffha_pkg::HDR_G + rdata_q.len;
	assign at_end  = (blk_end >= limit_q);
	assign fit     = !rdata_q.used && (rdata_q.len >= want_q);
	assign split   = {1'b0, rdata_q.len} > ({1'b0, want_q} + {1'b0, ffha_pkg::HDR_G});
	assign hit     = tgt_ok_q && (pos_q == tgt_q);
	assign miss    = !tgt_ok_q || (pos_q > tgt_q) || at_end;

	// clamp heap size to whole pages, expressed in granules
	always_comb begin
		if (wr_data[16])
			cfg_limit = ffha_pkg::MAX_G;
		else if (wr_data[15:12] == 4'd0)
			cfg_limit = 13'd256;
		else
			cfg_limit = {1'b0, wr_data[15:12], 8'd0};
	end

	// round request up to granules; a full heap or more saturates and never fits
	assign want_in = req.alloc_size[16] ? ffha_pkg::MAX_G :
	                 {1'b0, req.alloc_size[15:4]} + 13'(req.alloc_size[3:0] != 4'd0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffha_pkg::S_INIT: state_d = ffha_pkg::S_IDLE;
			ffha_pkg::S_IDLE: if (start) state_d = ffha_pkg::S_RD;
			ffha_pkg::S_RD:   state_d = ffha_pkg::S_EV;
			ffha_pkg::S_EV: begin
				if (func_q == ffha_pkg::FUNC_ALLOC) begin
					if (fit)
						state_d = split ? ffha_pkg::S_WR2 : ffha_pkg::S_IDLE;
					else
						state_d = at_end ? ffha_pkg::S_IDLE : ffha_pkg::S_RD;
				end else if (hit) begin
					state_d = at_end ? ffha_pkg::S_FWR : ffha_pkg::S_NRD;
				end else begin
					state_d = miss ? ffha_pkg::S_IDLE : ffha_pkg::S_RD;
				end
			end
			ffha_pkg::S_WR2: state_d = ffha_pkg::S_IDLE;
			ffha_pkg::S_NRD: state_d = ffha_pkg::S_NEV;
			ffha_pkg::S_NEV: state_d = ffha_pkg::S_FWR;
			ffha_pkg::S_FWR: state_d = ffha_pkg::S_IDLE;
			default:         state_d = ffha_pkg::S_IDLE;
		endcase
		if (wr_en) state_d = ffha_pkg::S_INIT;
	end

	// store write port and read address
	always_comb begin
		we      = 1'b0;
		wa      = pos_q[11:0];
		wd      = '0;
		rd_addr = (state_q == ffha_pkg::S_NRD) ? nxt_q[11:0] : pos_q[11:0];
		case (state_q)
			ffha_pkg::S_INIT: begin
				we = 1'b1;
				wa = 12'd0;
				wd = '{used: 1'b0, len: limit_q - ffha_pkg::HDR_G};
			end
			ffha_pkg::S_EV: begin
				if (func_q == ffha_pkg::FUNC_ALLOC && fit) begin
					we = 1'b1;
					wd = '{used: 1'b1, len: split ? want_q : rdata_q.len};
				end
			end
			ffha_pkg::S_WR2: begin
				we = 1'b1;
				wa = nxt_q[11:0];
				wd = '{used: 1'b0, len: rest_q};
			end
			ffha_pkg::S_FWR: begin
				we = 1'b1;
				wa = base_q[11:0];
				wd = '{used: 1'b0, len: acc_q};
			end
			default: we = 1'b0;
		endcase
	end

	// header store
	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rdata_q <= mem[rd_addr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::S_INIT;
			limit_q <= ffha_pkg::MAX_G;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) limit_q <= cfg_limit;
			case (state_q)
				ffha_pkg::S_EV: begin
					if (func_q == ffha_pkg::FUNC_ALLOC)
						done_q <= (fit && !split) || (!fit && at_end);
					else
						done_q <= !hit && miss;
				end
				ffha_pkg::S_WR2, ffha_pkg::S_FWR: done_q <= 1'b1;
				default: done_q <= 1'b0;
			endcase
		end
	end

	// walk and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ffha_pkg::S_IDLE: begin
				func_q      <= req.func;
				want_q      <= want_in;
				tgt_q       <= {1'b0, req.free_offset[15:4]} - ffha_pkg::HDR_G;
				tgt_ok_q    <= (req.free_offset[3:0] == 4'd0) &&
				               (req.free_offset[15:4] >= 12'(ffha_pkg::HDR_G));
				pos_q       <= '0;
				prev_free_q <= 1'b0;
				prev_pos_q  <= '0;
				prev_len_q  <= '0;
			end
			ffha_pkg::S_EV: begin
				if (func_q == ffha_pkg::FUNC_ALLOC && fit) begin
					rsp_q.given_offset <= {pos_q[11:0] + ffha_pkg::HDR_G[11:0], 4'd0};
					rsp_q.status       <= ffha_pkg::ST_ALLOCATED;
					nxt_q  <= pos_q + ffha_pkg::HDR_G + want_q;
					rest_q <= rdata_q.len - want_q - ffha_pkg::HDR_G;
				end else begin
					rsp_q.given_offset <= '0;
					rsp_q.status       <= (func_q == ffha_pkg::FUNC_ALLOC) ?
					                      ffha_pkg::ST_NO_FIT : ffha_pkg::ST_FREED;
				end
				if (func_q == ffha_pkg::FUNC_FREE && hit) begin
					base_q <= prev_free_q ? prev_pos_q : pos_q;
					acc_q  <= prev_free_q ?
					          prev_len_q + ffha_pkg::HDR_G + rdata_q.len : rdata_q.len;
					nxt_q  <= blk_end;
				end
				// advance to the next block
				prev_pos_q  <= pos_q;
				prev_len_q  <= rdata_q.len;
				prev_free_q <= !rdata_q.used;
				pos_q       <= blk_end;
			end
			ffha_pkg::S_NEV: begin
				// absorb a free right neighbour
				if (!rdata_q.used) acc_q <= acc_q + ffha_pkg::HDR_G + rdata_q.len;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ffha_pkg::S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	`AST_NEXT(a_done_pulse, clk, arst_n, done, !done)
	`AST_NEXT(a_accept_busy, clk, arst_n, start && !busy && !wr_en, busy)
	`AST_IMPLY(a_status_code, clk, arst_n, done, rsp.status != 2'd3)
	`AST_IMPLY(a_fail_zero, clk, arst_n, done && rsp.status != ffha_pkg::ST_ALLOCATED,
		rsp.given_offset == 16'd0)

endmodule

@@ verif/first_fit_heap_allocator_test.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_test
// Self-checking bench for the first-fit heap allocator. A behavioural copy
// of the block list predicts each result word; directed tests cover sizing
// edges, split rules, null and bad frees and register clamping, then random
// allocate/free traffic runs under several heap sizes.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_test;

	localparam int unsigned RUN_LIMIT = 20000000;

	typedef struct {
		int unsigned base;
		int unsigned len;
		bit          used;
	} block_t;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	ffha_pkg::req_t req;
	logic           done;
	ffha_pkg::rsp_t rsp;
	logic           wr_en;
	logic [16:0]    wr_data;

	// behavioural heap and pending results
	block_t         heap_blocks[$];
	int unsigned    heap_bytes;
	ffha_pkg::rsp_t pending_rsp[$];
	logic [15:0]    live_offsets[$];
	bit             failed;
	bit             gaps_on;
	int unsigned    cycle_count;

	first_fit_heap_allocator DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.req     (req),
		.done    (done),
		.rsp     (rsp),
		.wr_en   (wr_en),
		.wr_data (wr_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// rebuild the heap as one free block after clamping the size
	function automatic void rebuild_heap(input logic [16:0] v);
		int unsigned s;
		block_t      b;
		s = (int'(v) / 4096) * 4096;
		if (s < 4096) s = 4096;
		if (s > ffha_pkg::HEAP_BYTES) s = ffha_pkg::HEAP_BYTES;
		heap_bytes = s;
		heap_blocks.delete();
		b.base = 0;
		b.len  = s - ffha_pkg::HEADER_BYTES;
		b.used = 1'b0;
		heap_blocks.push_back(b);
	endfunction

	// first-fit walk for allocate, mark clear and merge for free
	function automatic ffha_pkg::rsp_t heap_step(input ffha_pkg::req_t r);
		ffha_pkg::rsp_t res;
		int unsigned    want;
		block_t         rest;
		int             i;
		res.given_offset = '0;
		res.status       = ffha_pkg::ST_FREED;
		if (r.func == ffha_pkg::FUNC_ALLOC) begin
			want = ((int'(r.alloc_size) + ffha_pkg::GRANULE_BYTES - 1) /
			        ffha_pkg::GRANULE_BYTES) * ffha_pkg::GRANULE_BYTES;
			res.status = ffha_pkg::ST_NO_FIT;
			for (i = 0; i < heap_blocks.size(); i++) begin
				if (!heap_blocks[i].used && heap_blocks[i].len >= want) begin
					if (heap_blocks[i].len > want + ffha_pkg::HEADER_BYTES &&
							heap_blocks.size() <
							ffha_pkg::HEAP_BYTES / ffha_pkg::HEADER_BYTES + 1) begin
						rest.base = heap_blocks[i].base + ffha_pkg::HEADER_BYTES + want;
						rest.len  = heap_blocks[i].len - want - ffha_pkg::HEADER_BYTES;
						rest.used = 1'b0;
						heap_blocks.insert(i + 1, rest);
						heap_blocks[i].len = want;
					end
					heap_blocks[i].used = 1'b1;
					res.given_offset = 16'(heap_blocks[i].base + ffha_pkg::HEADER_BYTES);
					res.status = ffha_pkg::ST_ALLOCATED;
					break;
				end
			end
		end else if (r.free_offset != 16'd0) begin
			for (i = 0; i < heap_blocks.size(); i++) begin
				if (heap_blocks[i].base + ffha_pkg::HEADER_BYTES == int'(r.free_offset)) begin
					heap_blocks[i].used = 1'b0;
					i = 0;
					while (i + 1 < heap_blocks.size()) begin
						if (!heap_blocks[i].used && !heap_blocks[i + 1].used) begin
							heap_blocks[i].len += ffha_pkg::HEADER_BYTES +
							                      heap_blocks[i + 1].len;
							heap_blocks.delete(i + 1);
						end else begin
							i++;
						end
					end
					break;
				end
			end
		end
		return res;
	endfunction

	function automatic ffha_pkg::req_t alloc_word(input logic [16:0] size);
		ffha_pkg::req_t r;
		r.func        = ffha_pkg::FUNC_ALLOC;
		r.alloc_size  = size;
		r.free_offset = 16'($urandom);
		return r;
	endfunction

	function automatic ffha_pkg::req_t free_word(input logic [15:0] off);
		ffha_pkg::req_t r;
		r.func        = ffha_pkg::FUNC_FREE;
		r.alloc_size  = 17'($urandom);
		r.free_offset = off;
		return r;
	endfunction

	// present one word with random idle cycles, hold until taken, then predict
	task automatic send_word(input ffha_pkg::req_t r);
		ffha_pkg::rsp_t res;
		bit             go;
		bit             taken;
		taken = 1'b0;
		req <= r;
		while (!taken) begin
			go = !(gaps_on && $urandom_range(0, 99) < 37);
			start <= go;
			@(posedge clk);
			taken = go && !busy;
		end
		res = heap_step(r);
		pending_rsp.push_back(res);
		if (res.status == ffha_pkg::ST_ALLOCATED && res.given_offset != 16'd0)
			live_offsets.push_back(res.given_offset);
	endtask

	// wait for the block to drain, then write the heap size
	task automatic write_heap_size(input logic [16:0] v);
		start <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0 || busy) @(posedge clk);
		wr_en   <= 1'b1;
		wr_data <= v;
		@(posedge clk);
		wr_en <= 1'b0;
		rebuild_heap(v);
		live_offsets.delete();
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic [15:0] take_live();
		int          k;
		logic [15:0] off;
		k   = $urandom_range(0, live_offsets.size() - 1);
		off = live_offsets[k];
		live_offsets.delete(k);
		return off;
	endfunction

	// sizing edges, zero size and no-fit on the full reset heap
	task automatic test_alloc_edges();
		send_word(alloc_word(17'd0));
		send_word(alloc_word(17'd1));
		send_word(alloc_word(17'd16));
		send_word(alloc_word(17'd17));
		send_word(alloc_word(17'h10000));
		send_word(alloc_word(17'h1FFFF));
	endtask

	// null, bad, valid and repeated frees
	task automatic test_free_cases();
		logic [15:0] off;
		send_word(free_word(16'd0));
		send_word(free_word(16'hFFFF));
		send_word(free_word(16'd5));
		off = take_live();
		send_word(free_word(off));
		send_word(free_word(off));
		while (live_offsets.size() != 0) send_word(free_word(take_live()));
	endtask

	// exact fit, rest of exactly one header, and a real split on a small heap
	task automatic test_split_rules();
		write_heap_size(17'd4096);
		send_word(alloc_word(17'd4064));
		send_word(alloc_word(17'd0));
		send_word(free_word(16'd32));
		send_word(alloc_word(17'd4032));
		send_word(free_word(16'd32));
		send_word(alloc_word(17'd4000));
		send_word(alloc_word(17'd16));
		send_word(free_word(16'd32));
		send_word(free_word(16'd4064));
	endtask

	// out-of-range sizes clamp up to one page, round down and saturate
	task automatic test_size_clamp();
		write_heap_size(17'd0);
		send_word(alloc_word(17'd4064));
		write_heap_size(17'h1FFFF);
		send_word(alloc_word(17'd65504));
		write_heap_size(17'd70000);
		send_word(alloc_word(17'd8191));
		write_heap_size(17'd12287);
		send_word(alloc_word(17'd8160));
	endtask

	// random traffic: mostly well-formed allocate/free, some noise
	task automatic test_random_traffic(input logic [16:0] size, input int n);
		int          roll;
		logic [16:0] sz;
		write_heap_size(size);
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (live_offsets.size() > 40 || (roll < 40 && live_offsets.size() != 0)) begin
				send_word(free_word(take_live()));
			end else if (roll < 88) begin
				roll = $urandom_range(0, 99);
				if (roll < 80) sz = 17'($urandom_range(0, 512));
				else if (roll < 96) sz = 17'($urandom_range(0, 4096));
				else sz = 17'($urandom);
				send_word(alloc_word(sz));
			end else if (roll < 94) begin
				send_word(free_word(16'($urandom)));
			end else begin
				send_word(free_word(16'd0));
			end
		end
	endtask

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected word, actual %h", $time, rsp);
				failed = 1'b1;
			end else begin
				if (rsp.given_offset !== pending_rsp[0].given_offset) begin
					$display("%0t: given_offset expected %h actual %h", $time,
						pending_rsp[0].given_offset, rsp.given_offset);
					failed = 1'b1;
				end
				if (rsp.status !== pending_rsp[0].status) begin
					$display("%0t: status expected %h actual %h", $time,
						pending_rsp[0].status, rsp.status);
					failed = 1'b1;
				end
				void'(pending_rsp.pop_front());
			end
		end
	end

	// abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("first_fit_heap_allocator regression: fail");
			$finish;
		end
	end

	initial begin
		failed      = 1'b0;
		gaps_on     = 1'b1;
		cycle_count = 0;
		arst_n  <= 1'b0;
		start   <= 1'b0;
		req     <= '0;
		wr_en   <= 1'b0;
		wr_data <= '0;
		rebuild_heap(17'(ffha_pkg::HEAP_BYTES));
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		test_alloc_edges();
		test_free_cases();
		test_split_rules();
		test_size_clamp();
		gaps_on = 1'b0;
		test_random_traffic(17'd65536, 150);
		gaps_on = 1'b1;
		test_random_traffic(17'd65536, 300);
		test_random_traffic(17'd4096, 200);
		test_random_traffic(17'd16384, 200);
		test_random_traffic(17'd32768, 150);

		// drain, then allow the block to settle
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (!failed) begin
			$display("first_fit_heap_allocator regression: pass");
		end else begin
			$display("first_fit_heap_allocator regression: fail");
		end
		$finish;
	end

endmodule
